@@ sv/fef_pkg.sv @@
// Shared constants, types and the color palette for the fire frame engine.
// No dependencies; all files but fef_ram import this package.
`default_nettype none
package fef_pkg;

  // Frame store geometry
  localparam int WIDTH      = 80;
  localparam int STORE_ROWS = 10;
  localparam int DEPTH      = WIDTH * STORE_ROWS;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int SEED_BASE  = (STORE_ROWS - 1) * WIDTH;

  // Fixed field widths
  localparam int ROW_W   = 6;
  localparam int COL_W   = 8;
  localparam int LEVEL_W = 8;
  localparam int SUM_W   = LEVEL_W + 2;

  // Palette band edges
  localparam logic [LEVEL_W-1:0] BAND_BLUE   = 8'd15;
  localparam logic [LEVEL_W-1:0] BAND_RED    = 8'd30;
  localparam logic [LEVEL_W-1:0] BAND_YELLOW = 8'd45;
  localparam logic [LEVEL_W-1:0] BAND_WHITE  = 8'd60;
  localparam logic [LEVEL_W-1:0] COOL_STEP   = 8'd4;

  // Item tag captured at the input handshake
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic [ADDR_W-1:0]  addr;
    logic               seed;
    logic [LEVEL_W-1:0] seed_level;
    logic               first_col;
    logic               last_col;
    logic               visible;
    logic               frame_done;
  } tag_t;

  // Updated cell handed to the color stage
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   column;
    logic [LEVEL_W-1:0] level;
    logic               visible;
    logic               frame_done;
  } cell_t;

  // One write to the frame store
  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [LEVEL_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic [3:0] r;
    logic [3:0] g;
    logic [3:0] b;
  } rgb_t;

  // Map a heat level to palette nibbles
  function automatic rgb_t palette(input logic [LEVEL_W-1:0] k);
    rgb_t c;
    if (k < BAND_BLUE) begin
      c.r = 4'd0;
      c.g = 4'd0;
      c.b = k[3:0];
    end else if (k < BAND_RED) begin
      c.r = 4'(k - BAND_BLUE);
      c.g = 4'd0;
      c.b = 4'(BAND_RED - k);
    end else if (k < BAND_YELLOW) begin
      c.r = 4'hF;
      c.g = 4'(k - BAND_RED);
      c.b = 4'd0;
    end else if (k < BAND_WHITE) begin
      c.r = 4'hF;
      c.g = 4'hF;
      c.b = 4'(k - BAND_YELLOW);
    end else begin
      c.r = 4'hF;
      c.g = 4'hF;
      c.b = 4'hF;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ sv/fef_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none
module fef_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [DATA_W-1:0]        rd_data_a,
  output logic      [DATA_W-1:0]        rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write, then read old contents on both ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

@@ sv/fef_sched.sv @@
// Input-side sequencer: clearing pass after reset, frame cursors, store reads.
// Depends on fef_pkg.
`default_nettype none
module fef_sched import fef_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [LEVEL_W-1:0] seed_level,
  output logic                    clearing,
  output wr_t                     clr_wr,
  output tag_t                    tag,
  output logic                    rd_en,
  output logic [ADDR_W-1:0]       rd_addr_a,
  output logic [ADDR_W-1:0]       rd_addr_b
);

  logic               seeding;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  clr_addr;

  // Describe the beat at the cursor
  always_comb begin
    tag.row        = row;
    tag.column     = col;
    tag.addr       = addr;
    tag.seed       = seeding;
    tag.seed_level = seed_level;
    tag.first_col  = (col == '0);
    tag.last_col   = (col == COL_W'(WIDTH - 1));
    tag.visible    = (row < ROW_W'(STORE_ROWS - 2));
    tag.frame_done = (row == ROW_W'(STORE_ROWS - 2)) && tag.last_col;
  end

  // Read cell and lower-right neighbor; at row end prefetch next row's lower start
  always_comb begin
    rd_en     = accept && !seeding;
    rd_addr_a = addr;
    if (tag.frame_done) begin
      rd_addr_b = ADDR_W'(WIDTH);
    end else begin
      rd_addr_b = addr + ADDR_W'(WIDTH + 1);
    end
  end

  // Zero the store one entry per cycle
  always_comb begin
    clr_wr.en   = clearing;
    clr_wr.addr = clr_addr;
    clr_wr.data = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Advance the cursors on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      seeding <= 1'b1;
      row     <= '0;
      col     <= '0;
      addr    <= ADDR_W'(SEED_BASE);
    end else if (accept) begin
      if (seeding) begin
        if (tag.last_col) begin
          seeding <= 1'b0;
          row     <= '0;
          col     <= '0;
          addr    <= '0;
        end else begin
          col  <= col + 1'b1;
          addr <= addr + 1'b1;
        end
      end else if (tag.frame_done) begin
        seeding <= 1'b1;
        row     <= '0;
        col     <= '0;
        addr    <= ADDR_W'(SEED_BASE);
      end else if (tag.last_col) begin
        row  <= row + 1'b1;
        col  <= '0;
        addr <= addr + 1'b1;
      end else begin
        col  <= col + 1'b1;
        addr <= addr + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/fef_update.sv @@
// Update stage: neighbor window, heat sum, cooling and write-back to the store.
// Depends on fef_pkg; sits behind the registered read ports of fef_ram.
`default_nettype none
module fef_update import fef_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire tag_t               tag_in,
  input  wire logic [LEVEL_W-1:0] rd_a,
  input  wire logic [LEVEL_W-1:0] rd_b,
  input  wire logic               down_free,
  output logic                    s1_valid,
  output logic                    s1_free,
  output wr_t                     wr,
  output logic                    push,
  output cell_t                   cell_out
);

  tag_t               tag1;
  logic               s1_go;
  logic [LEVEL_W-1:0] w_left;
  logic [LEVEL_W-1:0] w_mid;
  logic [LEVEL_W-1:0] side_l;
  logic [LEVEL_W-1:0] side_r;
  logic [SUM_W-1:0]   sum;
  logic [LEVEL_W-1:0] quarter;
  logic [LEVEL_W-1:0] lvl;

  // Seed beats retire here; update beats need room downstream
  assign s1_go   = s1_valid && (tag1.seed || down_free);
  assign s1_free = !s1_valid || s1_go;

  // Sum the cell and the three below, doubling the center at the edges
  always_comb begin
    side_l  = tag1.first_col ? w_mid : w_left;
    side_r  = tag1.last_col ? w_mid : rd_b;
    sum     = SUM_W'(rd_a) + SUM_W'(w_mid) + SUM_W'(side_l) + SUM_W'(side_r);
    quarter = sum[SUM_W-1:2];
    if (quarter > COOL_STEP) begin
      lvl = quarter - COOL_STEP;
    end else begin
      lvl = {1'b0, quarter[LEVEL_W-1:1]};
    end
  end

  // Write back the new level, or the seed into the bottom row
  always_comb begin
    wr.en               = s1_go;
    wr.addr             = tag1.addr;
    wr.data             = tag1.seed ? tag1.seed_level : lvl;
    push                = s1_go && !tag1.seed;
    cell_out.row        = tag1.row;
    cell_out.column     = tag1.column;
    cell_out.level      = lvl;
    cell_out.visible    = tag1.visible;
    cell_out.frame_done = tag1.frame_done;
  end

  // Hold the tag alongside the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      tag1 <= tag_in;
    end
  end

  // Slide the lower-row window; the store is zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      w_left <= '0;
      w_mid  <= '0;
    end else if (push) begin
      w_left <= w_mid;
      w_mid  <= rd_b;
    end
  end

endmodule
`default_nettype wire

@@ sv/fef_shade.sv @@
// Color stage and output register: palette lookup and result handshake.
// Depends on fef_pkg.
`default_nettype none
module fef_shade import fef_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire cell_t        cell_in,
  output logic              down_free,
  input  wire logic         result_ready,
  output logic              result_valid,
  output logic [ROW_W-1:0]  row,
  output logic [COL_W-1:0]  column,
  output logic [7:0]        level,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic              visible,
  output logic              frame_done
);

  logic  v2;
  cell_t c2;
  logic  o_load;
  rgb_t  rgb;

  assign o_load    = v2 && (!result_valid || result_ready);
  assign down_free = !v2 || o_load;
  assign rgb       = palette(c2.level);

  // Hold the updated cell for the palette
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (push) begin
      v2 <= 1'b1;
    end else if (o_load) begin
      v2 <= 1'b0;
    end
    if (push) begin
      c2 <= cell_in;
    end
  end

  // Present the beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (o_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (o_load) begin
      row        <= c2.row;
      column     <= c2.column;
      level      <= c2.level;
      red        <= {rgb.r, 4'd0};
      green      <= {rgb.g, 4'd0};
      blue       <= {rgb.b, 4'd0};
      visible    <= c2.visible;
      frame_done <= c2.frame_done;
    end
  end

endmodule
`default_nettype wire

@@ sv/fire_effect_frame_step.sv @@
// Fire animation frame engine: top level.
// Depends on fef_pkg, fef_ram, fef_sched, fef_update and fef_shade.
//
// Usage:
//   Input channel (item_valid/item_ready, seed_level): each frame takes WIDTH
//   seed beats that fill the bottom store row and give no result, then one
//   beat per cell of rows 0 to STORE_ROWS-2 in raster order.
//   Result channel (result_valid/result_ready): one beat per update beat with
//   row, column, new level, palette bytes, visible and frame_done.
//   Pipeline: three register stages (store read data, color stage, output
//   register).
//   Throughput: one beat per cycle when not stalled; the store has a write
//   port and two read ports; a three-cell lower-row window supplies the rest.
//   Reset: rst clears the pipeline and the cursors, then a clearing pass
//   zeros all STORE_ROWS*WIDTH (800) store entries with item_ready low.
//   Stall: while result_ready is low the output register holds; the color
//   stage and the update stage fill up, and item_ready drops once they are
//   full. Seed beats keep flowing while the update stage can retire them.
`default_nettype none
module fire_effect_frame_step import fef_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic [LEVEL_W-1:0] seed_level,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic [ROW_W-1:0]        row,
  output logic [COL_W-1:0]        column,
  output logic [7:0]              level,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue,
  output logic                    visible,
  output logic                    frame_done
);

  logic               accept;
  logic               clearing;
  wr_t                clr_wr;
  wr_t                upd_wr;
  wr_t                mem_wr;
  tag_t               tag;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr_a;
  logic [ADDR_W-1:0]  rd_addr_b;
  logic [LEVEL_W-1:0] rd_data_a;
  logic [LEVEL_W-1:0] rd_data_b;
  logic               s1_valid;
  logic               s1_free;
  logic               down_free;
  logic               push;
  cell_t              upd_cell;

  assign item_ready = !clearing && s1_free;
  assign accept     = item_valid && item_ready;

  // Clearing pass owns the write port until it ends
  assign mem_wr = clearing ? clr_wr : upd_wr;

  fef_sched u_sched (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .seed_level (seed_level),
    .clearing   (clearing),
    .clr_wr     (clr_wr),
    .tag        (tag),
    .rd_en      (rd_en),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b)
  );

  fef_ram #(
    .DATA_W (LEVEL_W),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk       (clk),
    .we        (mem_wr.en),
    .wr_addr   (mem_wr.addr),
    .wr_data   (mem_wr.data),
    .re        (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  fef_update u_update (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .tag_in    (tag),
    .rd_a      (rd_data_a),
    .rd_b      (rd_data_b),
    .down_free (down_free),
    .s1_valid  (s1_valid),
    .s1_free   (s1_free),
    .wr        (upd_wr),
    .push      (push),
    .cell_out  (upd_cell)
  );

  fef_shade u_shade (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .cell_in      (upd_cell),
    .down_free    (down_free),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .row          (row),
    .column       (column),
    .level        (level),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .visible      (visible),
    .frame_done   (frame_done)
  );

  // No beat is in flight while the store is being cleared
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !upd_wr.en)
    else $error("update stage busy during clearing pass");

  // Frame end lines up with the last updated cell
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && frame_done) |->
      (row == ROW_W'(STORE_ROWS - 2)) && (column == COL_W'(WIDTH - 1)))
    else $error("frame_done on a cell other than the last one");

  // Visibility travels with its row
  a_visible: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (visible == (row < ROW_W'(STORE_ROWS - 2))))
    else $error("visible flag does not match row");

endmodule
`default_nettype wire
